// ----- sv/tfs_pkg.sv -----
// ----------------------------------------------------------------------------
// tfs_pkg - shared constants and types for the flat shading pipeline
// Shade range, light register codes and reset values, pipeline control word.
// ----------------------------------------------------------------------------
package tfs_pkg;

   localparam int COORD_BITS_DEF = 16;
   localparam int LIGHT_BITS     = 16;
   localparam int SHADE_BITS     = 8;

   localparam int SHADE_BASE     = 40;
   localparam int SHADE_MAX      = 235;
   localparam int K_MAX          = SHADE_MAX - SHADE_BASE;
   localparam int K_BITS         = 8;
   localparam int SHADE_SPAN     = 175;
   localparam int SPAN_BITS      = 8;
   localparam int KSCALE_SHIFT   = 30;

   // floor(s*24/25) as (s*31458) >> 15, exact for s up to 255
   localparam int BLUE_MUL       = 31458;
   localparam int BLUE_SHIFT     = 15;
   localparam int BLUE_MUL_BITS  = 15;

   localparam int CSR_IDX_BITS   = 2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LIGHT_X = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LIGHT_Y = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LIGHT_Z = 2'd2;

   localparam logic [LIGHT_BITS-1:0] LIGHT_X_RST = 16'd13816;
   localparam logic [LIGHT_BITS-1:0] LIGHT_Y_RST = 16'd24180;
   localparam logic [LIGHT_BITS-1:0] LIGHT_Z_RST = 16'd17270;

   typedef struct packed {
      logic valid;
      logic degenerate;
   } tfs_ctl_type;

endpackage

// ----- sv/triangle_flat_shade.sv -----
// ----------------------------------------------------------------------------
// triangle_flat_shade - two-sided flat Lambert shade of one triangle
// Exact face normal, scaled shade level search, colour output register.
// ----------------------------------------------------------------------------
// usage:
//   pulse start with the nine vertex coordinates on req_*; busy is always low,
//   so a triangle is taken on every cycle that start is high.
//   each triangle gives one colour word on rsp_* with rsp_valid high for one
//   cycle, in order of arrival.
//   throughput is one triangle per clock; the pipeline is made of
//   3 normal stages, 4 dot and squaring stages, 8 search stages (one bit of
//   the shade step each) and the output register.
//   the light direction is written through csr_we/csr_index/csr_wdata and
//   should only change while nothing is in flight.
//   reset clears all valid bits and loads the default light direction.
//   the receiver cannot stall; every result word is presented exactly once.
// ----------------------------------------------------------------------------
module triangle_flat_shade
   import tfs_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [COORD_BITS-1:0] req_vertex_a_x,
   input  logic signed [COORD_BITS-1:0] req_vertex_a_y,
   input  logic signed [COORD_BITS-1:0] req_vertex_a_z,
   input  logic signed [COORD_BITS-1:0] req_vertex_b_x,
   input  logic signed [COORD_BITS-1:0] req_vertex_b_y,
   input  logic signed [COORD_BITS-1:0] req_vertex_b_z,
   input  logic signed [COORD_BITS-1:0] req_vertex_c_x,
   input  logic signed [COORD_BITS-1:0] req_vertex_c_y,
   input  logic signed [COORD_BITS-1:0] req_vertex_c_z,
   input  logic                         csr_we,
   input  logic [CSR_IDX_BITS-1:0]      csr_index,
   input  logic [LIGHT_BITS-1:0]        csr_wdata,
   output logic                         rsp_valid,
   output logic [SHADE_BITS-1:0]        rsp_shade_red,
   output logic [SHADE_BITS-1:0]        rsp_shade_green,
   output logic [SHADE_BITS-1:0]        rsp_shade_blue,
   output logic                         rsp_degenerate
);

   localparam int NW  = 2*COORD_BITS + 2;
   localparam int MW  = NW - 1;
   localparam int AW  = 2*MW + 2 + KSCALE_SHIFT;
   localparam int RW  = 2*(MW + 26);
   localparam int LAT = 16;
   localparam int BPW = SHADE_BITS + BLUE_MUL_BITS;

   logic signed [COORD_BITS-1:0] va [3];
   logic signed [COORD_BITS-1:0] vb [3];
   logic signed [COORD_BITS-1:0] vc [3];
   logic signed [NW-1:0]         n_w [3];
   logic signed [LIGHT_BITS-1:0] light_ff [3];
   logic [AW-1:0]                a_w;
   logic [RW-1:0]                r_w;
   logic [K_BITS-1:0]            k_w, kc_w;
   logic [SHADE_BITS-1:0]        shade_w;
   logic [BPW-1:0]               blue_w;
   tfs_ctl_type                  c_norm, c_dot, c_root;
   logic                         valid_ff;
   logic [SHADE_BITS-1:0]        shade_ff, blue_ff;
   logic                         degen_ff;

   assign busy = 1'b0;

   assign va = '{req_vertex_a_x, req_vertex_a_y, req_vertex_a_z};
   assign vb = '{req_vertex_b_x, req_vertex_b_y, req_vertex_b_z};
   assign vc = '{req_vertex_c_x, req_vertex_c_y, req_vertex_c_z};

   always_ff @(posedge clock) begin
      if (reset) begin
         light_ff[0] <= LIGHT_X_RST;
         light_ff[1] <= LIGHT_Y_RST;
         light_ff[2] <= LIGHT_Z_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LIGHT_X: light_ff[0] <= csr_wdata;
            CSR_LIGHT_Y: light_ff[1] <= csr_wdata;
            CSR_LIGHT_Z: light_ff[2] <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   tfs_normal #(.COORD_BITS(COORD_BITS)) u_normal (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start & ~busy),
      .va       (va),
      .vb       (vb),
      .vc       (vc),
      .ctl_out  (c_norm),
      .n_out    (n_w)
   );

   tfs_dot #(.COORD_BITS(COORD_BITS), .NW(NW), .AW(AW), .RW(RW)) u_dot (
      .clock   (clock),
      .reset   (reset),
      .ctl_in  (c_norm),
      .n_in    (n_w),
      .light   (light_ff),
      .ctl_out (c_dot),
      .a_out   (a_w),
      .r_out   (r_w)
   );

   tfs_root #(.AW(AW), .RW(RW)) u_root (
      .clock   (clock),
      .reset   (reset),
      .ctl_in  (c_dot),
      .a_in    (a_w),
      .r_in    (r_w),
      .ctl_out (c_root),
      .k_out   (k_w)
   );

   // zero normal passes every trial, so force the base level there
   always_comb begin
      priority if (c_root.degenerate) begin
         kc_w = '0;
      end else if (k_w > K_BITS'(K_MAX)) begin
         kc_w = K_BITS'(K_MAX);
      end else begin
         kc_w = k_w;
      end
      shade_w = SHADE_BITS'(SHADE_BASE) + kc_w;
      blue_w  = BPW'(shade_w) * BPW'(BLUE_MUL);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= c_root.valid;
      end
   end

   always_ff @(posedge clock) begin
      shade_ff <= shade_w;
      blue_ff  <= blue_w[BLUE_SHIFT +: SHADE_BITS];
      degen_ff <= c_root.degenerate;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_shade_red   = shade_ff;
   assign rsp_shade_green = shade_ff;
   assign rsp_shade_blue  = blue_ff;
   assign rsp_degenerate  = degen_ff;

   a_latency : assert property (@(posedge clock) disable iff (reset)
      start |-> ##LAT rsp_valid)
      else $error("result word missing after pipeline latency");

   a_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_shade_red >= SHADE_BITS'(SHADE_BASE)) &&
                    (rsp_shade_red <= SHADE_BITS'(SHADE_MAX)))
      else $error("shade level out of range");

   a_degen : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_shade_red == SHADE_BITS'(SHADE_BASE))
      else $error("degenerate triangle not at base shade");

   a_blue : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_shade_blue <= rsp_shade_red) &&
                    (rsp_shade_blue + SHADE_BITS'(10) >= rsp_shade_red))
      else $error("blue channel inconsistent with shade");

endmodule

// ----- sv/tfs_normal.sv -----
// ----------------------------------------------------------------------------
// tfs_normal - face normal stages
// Edges, cross product partial products and exact normal with zero flag.
// ----------------------------------------------------------------------------
module tfs_normal
   import tfs_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic signed [COORD_BITS-1:0] va [3],
   input  logic signed [COORD_BITS-1:0] vb [3],
   input  logic signed [COORD_BITS-1:0] vc [3],
   output tfs_ctl_type                 ctl_out,
   output logic signed [2*COORD_BITS+1:0] n_out [3]
);

   localparam int E  = COORD_BITS + 1;
   localparam int PW = 2*E - 1;
   localparam int NW = 2*E;

   logic signed [E-1:0]   e1_in [3];
   logic signed [E-1:0]   e2_in [3];
   logic signed [E-1:0]   e1_ff [3];
   logic signed [E-1:0]   e2_ff [3];
   logic signed [2*E-1:0] mul_in [6];
   logic signed [PW-1:0]  pr_ff [6];
   logic signed [NW-1:0]  n_in [3];
   logic signed [NW-1:0]  n_ff [3];
   logic                  v1_ff, v2_ff;
   tfs_ctl_type           ctl_in, ctl_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         e1_in[i] = E'(vb[i]) - E'(va[i]);
         e2_in[i] = E'(vc[i]) - E'(va[i]);
      end
      mul_in[0] = e1_ff[1] * e2_ff[2];
      mul_in[1] = e1_ff[2] * e2_ff[1];
      mul_in[2] = e1_ff[2] * e2_ff[0];
      mul_in[3] = e1_ff[0] * e2_ff[2];
      mul_in[4] = e1_ff[0] * e2_ff[1];
      mul_in[5] = e1_ff[1] * e2_ff[0];
      for (int i = 0; i < 3; i++) begin
         n_in[i] = NW'(pr_ff[2*i]) - NW'(pr_ff[2*i+1]);
      end
      ctl_in.valid      = v2_ff;
      ctl_in.degenerate = (pr_ff[0] == pr_ff[1]) && (pr_ff[2] == pr_ff[3]) &&
                          (pr_ff[4] == pr_ff[5]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         ctl_ff <= '0;
      end else begin
         v1_ff  <= in_valid;
         v2_ff  <= v1_ff;
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      e1_ff <= e1_in;
      e2_ff <= e2_in;
      for (int i = 0; i < 6; i++) begin
         pr_ff[i] <= mul_in[i][PW-1:0];
      end
      n_ff <= n_in;
   end

   assign ctl_out = ctl_ff;
   assign n_out   = n_ff;

endmodule

// ----- sv/tfs_dot.sv -----
// ----------------------------------------------------------------------------
// tfs_dot - squared length and scaled squared dot product
// Produces a = n.n * 2^30 and r = (175*|n.L|)^2, split multiplies staged.
// ----------------------------------------------------------------------------
module tfs_dot
   import tfs_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int NW = 2*COORD_BITS + 2,
   parameter int AW = 2*(2*COORD_BITS + 1) + 2 + KSCALE_SHIFT,
   parameter int RW = 2*(2*COORD_BITS + 1 + 26)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  tfs_ctl_type                  ctl_in,
   input  logic signed [NW-1:0]         n_in [3],
   input  logic signed [LIGHT_BITS-1:0] light [3],
   output tfs_ctl_type                  ctl_out,
   output logic [AW-1:0]                a_out,
   output logic [RW-1:0]                r_out
);

   localparam int MW   = NW - 1;
   localparam int NNW  = 2*MW + 2;
   localparam int PDW  = NW + LIGHT_BITS;
   localparam int DOTW = PDW + 2;
   localparam int DW0  = DOTW - 1;
   localparam int DW   = DW0 + SPAN_BITS;
   localparam int HALF = (DW + 1) / 2;
   localparam int HB   = DW - HALF;

   logic [MW-1:0]          mag_in [3];
   logic [2*MW-1:0]        sq_in [3];
   logic [2*MW-1:0]        sq_ff [3];
   logic signed [PDW-1:0]  p_in [3];
   logic signed [PDW-1:0]  p_ff [3];
   logic signed [DOTW-1:0] dot_w, dabs_w;
   logic [DW-1:0]          d175_in, d175_ff;
   logic [NNW-1:0]         nn_in, nn5_ff, nn6_ff;
   logic [HB-1:0]          hi_w;
   logic [HALF-1:0]        lo_w;
   logic [2*HB-1:0]        hh_in, hh_ff;
   logic [HB+HALF-1:0]     hl_in, hl_ff;
   logic [2*HALF-1:0]      ll_in, ll_ff;
   logic [RW-1:0]          r_in, r_ff;
   logic [AW-1:0]          a_in, a_ff;
   tfs_ctl_type            c4_ff, c5_ff, c6_ff, c7_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag_in[i] = n_in[i][NW-1] ? MW'(-n_in[i]) : MW'(n_in[i]);
         sq_in[i]  = mag_in[i] * mag_in[i];
         p_in[i]   = n_in[i] * light[i];
      end
      nn_in   = NNW'(sq_ff[0]) + NNW'(sq_ff[1]) + NNW'(sq_ff[2]);
      dot_w   = DOTW'(p_ff[0]) + DOTW'(p_ff[1]) + DOTW'(p_ff[2]);
      dabs_w  = dot_w[DOTW-1] ? -dot_w : dot_w;
      d175_in = DW'(dabs_w[DW0-1:0]) * DW'(SHADE_SPAN);
      hi_w    = d175_ff[DW-1:HALF];
      lo_w    = d175_ff[HALF-1:0];
      hh_in   = hi_w * hi_w;
      hl_in   = (HB+HALF)'(hi_w) * (HB+HALF)'(lo_w);
      ll_in   = lo_w * lo_w;
      // (h*2^H + l)^2 = h^2*2^2H + 2hl*2^H + l^2
      r_in    = (RW'(hh_ff) << (2*HALF)) + (RW'(hl_ff) << (HALF+1)) + RW'(ll_ff);
      a_in    = AW'(nn6_ff) << KSCALE_SHIFT;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c4_ff <= '0;
         c5_ff <= '0;
         c6_ff <= '0;
         c7_ff <= '0;
      end else begin
         c4_ff <= ctl_in;
         c5_ff <= c4_ff;
         c6_ff <= c5_ff;
         c7_ff <= c6_ff;
      end
   end

   always_ff @(posedge clock) begin
      sq_ff   <= sq_in;
      p_ff    <= p_in;
      nn5_ff  <= nn_in;
      d175_ff <= d175_in;
      nn6_ff  <= nn5_ff;
      hh_ff   <= hh_in;
      hl_ff   <= hl_in;
      ll_ff   <= ll_in;
      r_ff    <= r_in;
      a_ff    <= a_in;
   end

   assign ctl_out = c7_ff;
   assign a_out   = a_ff;
   assign r_out   = r_ff;

endmodule

// ----- sv/tfs_root.sv -----
// ----------------------------------------------------------------------------
// tfs_root - bit-serial search for k, one bit per stage
// Largest k with k^2*a <= r, by restoring square root steps on r - k^2*a.
// ----------------------------------------------------------------------------
module tfs_root
   import tfs_pkg::*;
#(
   parameter int AW = 2*(2*COORD_BITS_DEF + 1) + 2 + KSCALE_SHIFT,
   parameter int RW = 2*(2*COORD_BITS_DEF + 1 + 26)
) (
   input  logic              clock,
   input  logic              reset,
   input  tfs_ctl_type       ctl_in,
   input  logic [AW-1:0]     a_in,
   input  logic [RW-1:0]     r_in,
   output tfs_ctl_type       ctl_out,
   output logic [K_BITS-1:0] k_out
);

   localparam int BW = AW + K_BITS;

   tfs_ctl_type       ctl_ff [K_BITS];
   logic [K_BITS-1:0] k_ff   [K_BITS];
   logic [RW-1:0]     rem_ff [K_BITS-1];
   logic [BW-1:0]     b_ff   [K_BITS-1];
   logic [AW-1:0]     a_ff   [K_BITS-1];

   for (genvar s = 0; s < K_BITS; s++) begin : g_step
      localparam int J = K_BITS - 1 - s;

      tfs_ctl_type       ctl_s;
      logic [K_BITS-1:0] k_s;
      logic [RW-1:0]     rem_s, trial_s;
      logic [BW-1:0]     b_s;
      logic [AW-1:0]     a_s;
      logic              take_s;

      if (s == 0) begin : g_first
         assign ctl_s = ctl_in;
         assign k_s   = '0;
         assign rem_s = r_in;
         assign b_s   = '0;
         assign a_s   = a_in;
      end else begin : g_next
         assign ctl_s = ctl_ff[s-1];
         assign k_s   = k_ff[s-1];
         assign rem_s = rem_ff[s-1];
         assign b_s   = b_ff[s-1];
         assign a_s   = a_ff[s-1];
      end

      // (k + 2^j)^2*a - k^2*a = (k*a)*2^(j+1) + a*2^2j
      assign trial_s = (RW'(b_s) << (J+1)) + (RW'(a_s) << (2*J));
      assign take_s  = trial_s <= rem_s;

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[s] <= '0;
         end else begin
            ctl_ff[s] <= ctl_s;
         end
      end

      always_ff @(posedge clock) begin
         k_ff[s] <= take_s ? (k_s | K_BITS'(1 << J)) : k_s;
      end

      if (s < K_BITS - 1) begin : g_carry
         always_ff @(posedge clock) begin
            rem_ff[s] <= take_s ? rem_s - trial_s : rem_s;
            b_ff[s]   <= take_s ? b_s + (BW'(a_s) << J) : b_s;
            a_ff[s]   <= a_s;
         end
      end
   end

   assign ctl_out = ctl_ff[K_BITS-1];
   assign k_out   = k_ff[K_BITS-1];

endmodule
